@@ rtl/bce_pkg.sv @@
// ----------------------------------------------------------------------------
// bce_pkg - shared definitions for the bezier curve evaluator
// coordinate type, parameter format constants and register indexes
// ----------------------------------------------------------------------------
package bce_pkg;

    // signed Q15.16 coordinate
    localparam int COORD_W = 32;
    typedef logic signed [COORD_W-1:0] coord_t;

    // unsigned Q1.16 curve parameter
    localparam int PARAM_W = 17;
    typedef logic [PARAM_W-1:0] param_t;
    localparam param_t T_ONE = param_t'(65536);
    localparam int FRAC_W = 16;

    // difference and product widths
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = 50;

    // control points
    localparam int MAX_POINTS     = 4;
    localparam int DEFAULT_POINTS = 4;

    // configuration register map
    localparam int NUM_REGS = 2 * MAX_POINTS;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_P0_X = 3'd0,
        REG_P0_Y = 3'd1,
        REG_P1_X = 3'd2,
        REG_P1_Y = 3'd3,
        REG_P2_X = 3'd4,
        REG_P2_Y = 3'd5,
        REG_P3_X = 3'd6,
        REG_P3_Y = 3'd7
    } reg_code_t;

    // register stages in one interpolation level
    localparam int LEVEL_STAGES = 3;

endpackage

@@ rtl/bce_lerp.sv @@
// ----------------------------------------------------------------------------
// bce_lerp - one interpolation lane
// a + ((b - a) * t) >>> 16 over three register stages
// ----------------------------------------------------------------------------
module bce_lerp (
    input  logic            clk,
    input  bce_pkg::coord_t a,
    input  bce_pkg::coord_t b,
    input  bce_pkg::param_t t_d1,   // t aligned with the difference register
    output bce_pkg::coord_t y
);

    localparam int DIFF_W = bce_pkg::DIFF_W;
    localparam int PROD_W = bce_pkg::PROD_W;
    localparam int COORD_W = bce_pkg::COORD_W;
    localparam int FRAC_W = bce_pkg::FRAC_W;
    localparam int SUM_W = PROD_W - FRAC_W;

    bce_pkg::coord_t            a1_reg;
    bce_pkg::coord_t            a2_reg;
    logic signed [DIFF_W-1:0]   diff_reg;
    logic signed [DIFF_W-1:0]   diff_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [DIFF_W+bce_pkg::PARAM_W:0] prod_full;
    logic signed [SUM_W-1:0]    sum;
    bce_pkg::coord_t            y_reg;

    always_comb
    begin
        diff_next = DIFF_W'(b) - DIFF_W'(a);
        prod_full = diff_reg * $signed({1'b0, t_d1});
        // product always fits in PROD_W bits
        prod_next = prod_full[PROD_W-1:0];
        // arithmetic shift: keep the upper bits of the product
        sum = SUM_W'(a2_reg) + prod_reg[PROD_W-1:FRAC_W];
    end

    always_ff @(posedge clk)
    begin
        a1_reg   <= a;
        diff_reg <= diff_next;
        a2_reg   <= a1_reg;
        prod_reg <= prod_next;
        y_reg    <= sum[COORD_W-1:0];
    end

    assign y = y_reg;

endmodule

@@ rtl/bce_level.sv @@
// ----------------------------------------------------------------------------
// bce_level - one de casteljau level
// reduces LANES+1 points to LANES points, x and y lanes side by side
// ----------------------------------------------------------------------------
module bce_level #(
    parameter int LANES = 1
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  bce_pkg::param_t                        in_t,
    input  logic [LANES:0][bce_pkg::COORD_W-1:0]   in_x,
    input  logic [LANES:0][bce_pkg::COORD_W-1:0]   in_y,
    output logic                                   out_valid,
    output bce_pkg::param_t                        out_t,
    output logic [LANES-1:0][bce_pkg::COORD_W-1:0] out_x,
    output logic [LANES-1:0][bce_pkg::COORD_W-1:0] out_y
);

    localparam int STAGES = bce_pkg::LEVEL_STAGES;

    logic [STAGES-1:0]  valid_reg;
    bce_pkg::param_t    t_reg [STAGES];

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg[0] <= in_t;
        for (int s = 1; s < STAGES; s++)
        begin
            t_reg[s] <= t_reg[s-1];
        end
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        bce_lerp u_lerp_x (
            .clk  (clk),
            .a    (in_x[i]),
            .b    (in_x[i+1]),
            .t_d1 (t_reg[0]),
            .y    (out_x[i])
        );
        bce_lerp u_lerp_y (
            .clk  (clk),
            .a    (in_y[i]),
            .b    (in_y[i+1]),
            .t_d1 (t_reg[0]),
            .y    (out_y[i])
        );
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_t     = t_reg[STAGES-1];

endmodule

@@ rtl/bezier_curve_evaluator.sv @@
// ----------------------------------------------------------------------------
// bezier_curve_evaluator - fixed-point cubic bezier point evaluation
// de casteljau reduction of up to four control points, fully pipelined
// ----------------------------------------------------------------------------
// One item per clock: start may be high in every cycle and busy is always
// low, since the pipeline never stalls and the receiver cannot hold results
// off. An accepted item passes one input register, three stages per de
// casteljau level (difference, multiply, shift and add) and one output
// register, and its point then shows on curve_x / curve_y with done high.
// Control points are read straight from the configuration registers, so
// they must only be rewritten while no item is in flight. A parameter above
// one is clamped to one.
// ----------------------------------------------------------------------------
module bezier_curve_evaluator #(
    parameter int POINTS = bce_pkg::DEFAULT_POINTS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          wr_en,
    input  bce_pkg::reg_idx_t             wr_index,
    input  logic [bce_pkg::COORD_W-1:0]   wr_data,
    // item in
    input  logic                          start,
    output logic                          busy,
    input  logic [bce_pkg::PARAM_W-1:0]   curve_param,
    // result out
    output logic                          done,
    output logic signed [bce_pkg::COORD_W-1:0] curve_x,
    output logic signed [bce_pkg::COORD_W-1:0] curve_y
);

    localparam int COORD_W  = bce_pkg::COORD_W;
    localparam int NUM_REGS = bce_pkg::NUM_REGS;
    localparam int LATENCY  = bce_pkg::LEVEL_STAGES * (POINTS - 1) + 2;

    // control point registers
    bce_pkg::coord_t cfg_reg [NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_REGS; r++)
            begin
                cfg_reg[r] <= '0;
            end
        end
        else if (wr_en)
        begin
            cfg_reg[wr_index] <= wr_data;
        end
    end

    // pipeline never stalls
    assign busy = 1'b0;

    // input stage: clamp t to one
    logic            v_in_reg;
    bce_pkg::param_t t_in_reg;
    bce_pkg::param_t t_in_next;
    logic            accept;

    assign accept = start && !busy;

    always_comb
    begin
        t_in_next = (curve_param > bce_pkg::T_ONE) ? bce_pkg::T_ONE : curve_param;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_in_reg <= 1'b0;
        end
        else
        begin
            v_in_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        t_in_reg <= t_in_next;
    end

    // level chain: entry k holds the points entering level k
    logic                               chain_v [POINTS];
    bce_pkg::param_t                    chain_t [POINTS];
    logic [POINTS-1:0][COORD_W-1:0]     chain_x [POINTS];
    logic [POINTS-1:0][COORD_W-1:0]     chain_y [POINTS];

    assign chain_v[0] = v_in_reg;
    assign chain_t[0] = t_in_reg;

    // level zero takes the used control points
    for (genvar i = 0; i < POINTS; i++)
    begin : g_points
        assign chain_x[0][i] = cfg_reg[2*i];
        assign chain_y[0][i] = cfg_reg[2*i+1];
    end

    for (genvar k = 0; k < POINTS - 1; k++)
    begin : g_level
        bce_level #(
            .LANES (POINTS - k - 1)
        ) u_level (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_v[k]),
            .in_t      (chain_t[k]),
            .in_x      (chain_x[k][POINTS-k-1:0]),
            .in_y      (chain_y[k][POINTS-k-1:0]),
            .out_valid (chain_v[k+1]),
            .out_t     (chain_t[k+1]),
            .out_x     (chain_x[k+1][POINTS-k-2:0]),
            .out_y     (chain_y[k+1][POINTS-k-2:0])
        );
        // slots that the shrinking point set leaves empty
        assign chain_x[k+1][POINTS-1:POINTS-k-1] = '0;
        assign chain_y[k+1][POINTS-1:POINTS-k-1] = '0;
    end

    // output register: one point per item, shown for one cycle
    logic            done_reg;
    bce_pkg::coord_t x_reg;
    bce_pkg::coord_t y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= chain_v[POINTS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= chain_x[POINTS-1][0];
        y_reg <= chain_y[POINTS-1][0];
    end

    assign done    = done_reg;
    assign curve_x = x_reg;
    assign curve_y = y_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // every result traces back to an item accepted a fixed latency earlier
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without a matching item");

    // clamped parameter never exceeds one
    a_t_clamped : assert property (@(posedge clk) disable iff (!rst_n)
        v_in_reg |-> (t_in_reg <= bce_pkg::T_ONE))
        else $error("curve parameter not clamped");

    // no result in the cycle straight after reset
    a_reset_quiet : assert property (@(posedge clk)
        $past(!rst_n) |-> !done)
        else $error("result right after reset");

endmodule
